// ----- rtl/core/kmp_pkg.sv -----
// Shared types, constants and helpers for the streaming KMP matcher.
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Widths fixed by the register and payload formats.
    localparam int LEN_W       = 5;
    localparam int PAT_W       = 128;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int START_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic               match_found;
        logic [START_W-1:0] match_start;
    } t_out;

    typedef struct packed {
        logic             busy;
        logic [LEN_W-1:0] fail_last;
    } t_tbl_status;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_CLEAR,
        TBL_BUILD
    } t_tbl_state;

    typedef enum logic {
        ENG_IDLE,
        ENG_STEP
    } t_eng_state;

    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat, input logic [3:0] k);
        return pat[{k, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kmp_stream_matcher.sv -----
// Top level of the streaming KMP matcher: config registers, queues, table and engine.
// Flow: an accepted item waits in the input queue until the engine is idle and the table
// is not busy; the engine then follows failure links and pushes the result into the
// output queue once it has space. The engine takes no new byte before it has pushed the
// result of the last one; failure links followed never outnumber bytes over a text.
// Reset clears pattern, length, failure table, progress and position. A write to the
// length or either pattern register rebuilds the table, with full high meanwhile.
`default_nettype none

module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire t_in                   i_in,
    output logic                       empty,
    input  wire logic                  pop,
    output t_out                       o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0]      r_len;
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic                  cfg_wr;
    logic                  cfg_known;
    logic [LW-1:0]         len_eff;
    logic [PAT_W-1:0]      pattern;
    t_in                   q_item;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    t_tbl_status           tbl_st;
    logic [IW-1:0]         eng_addr;
    logic [LW-1:0]         tbl_data;
    t_out                  eng_res;
    logic                  res_push;
    logic                  res_full;
    logic                  eng_idle;

    assign pattern = {r_pat_hi, r_pat_lo};
    assign len_eff = (r_len > LEN_W'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(r_len);

    // Registers change only with no item in flight and the table settled.
    assign o_cfg_ready = !tbl_st.busy && eng_idle && q_empty;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign full        = q_full || tbl_st.busy;

    always_comb begin
        unique case (i_cfg_index) inside
            CFG_LENGTH, CFG_PATTERN_LOW, CFG_PATTERN_HIGH: cfg_known = 1'b1;
            default:                                      cfg_known = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_LENGTH:       r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:  r_pat_lo <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_hi <= i_cfg_data;
                default:          r_len    <= r_len;
            endcase
        end
    end

    kmp_queue #(
        .W($bits(t_in))
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (i_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    kmp_table #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cfg_wr && cfg_known),
        .i_len      (len_eff),
        .i_pattern  (pattern),
        .i_eng_addr (eng_addr),
        .o_rd_data  (tbl_data),
        .o_status   (tbl_st)
    );

    kmp_engine #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (cfg_wr && cfg_known),
        .i_len        (len_eff),
        .i_pattern    (pattern),
        .i_item       (q_item),
        .i_item_valid (!q_empty),
        .o_item_pop   (q_pop),
        .i_tbl        (tbl_st),
        .o_rd_addr    (eng_addr),
        .i_rd_data    (tbl_data),
        .o_res        (eng_res),
        .o_res_push   (res_push),
        .i_res_full   (res_full),
        .o_idle       (eng_idle)
    );

    kmp_queue #(
        .W($bits(t_out))
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (eng_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// ----- rtl/core/kmp_queue.sv -----
// Two-entry queue that decouples the item flow between two parts of the matcher.
`default_nettype none

module kmp_queue
    import kmp_pkg::*;
#(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= !r_wr;
            end
            if (pop_ok) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/kmp_table.sv -----
// Failure table storage and the sequencer that rebuilds it from the pattern.
`default_nettype none

module kmp_table
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1),
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [LW-1:0]    i_len,
    input  wire logic [PAT_W-1:0] i_pattern,
    input  wire logic [IW-1:0]    i_eng_addr,
    output logic [LW-1:0]         o_rd_data,
    output t_tbl_status           o_status
);

    logic [LW-1:0] r_fail [MAX_PATTERN];
    t_tbl_state    r_state;
    t_tbl_state    n_state;
    logic [LW-1:0] r_i;
    logic [LW-1:0] n_i;
    logic [LW-1:0] r_j;
    logic [LW-1:0] n_j;
    logic [LW-1:0] r_last;
    logic [LW-1:0] n_last;
    logic          clr;
    logic          we;
    logic [LW-1:0] jp;
    logic [IW-1:0] rd_addr;
    logic [7:0]    pi;
    logic [7:0]    pj;

    // The builder owns the read port while it runs; the engine is idle then.
    assign rd_addr   = (r_state != TBL_IDLE) ? IW'(r_j - LW'(1)) : i_eng_addr;
    assign o_rd_data = r_fail[rd_addr];
    assign o_status.busy      = (r_state != TBL_IDLE);
    assign o_status.fail_last = LEN_W'(r_last);

    assign pi = pat_byte(i_pattern, 4'(r_i));
    assign pj = pat_byte(i_pattern, 4'(r_j));
    assign jp = r_j + LW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TBL_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_fail[k] <= '0;
            end
        end else if (we) begin
            r_fail[IW'(r_i)] <= jp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_last  = r_last;
        clr     = 1'b0;
        we      = 1'b0;
        unique case (r_state)
            TBL_IDLE: begin
                if (i_start) begin
                    n_state = TBL_CLEAR;
                end
            end
            TBL_CLEAR: begin
                clr     = 1'b1;
                n_last  = '0;
                n_i     = LW'(1);
                n_j     = '0;
                n_state = (i_len > LW'(1)) ? TBL_BUILD : TBL_IDLE;
            end
            TBL_BUILD: begin
                if (r_j != '0 && pi != pj) begin
                    n_j = o_rd_data;
                end else begin
                    if (pi == pj) begin
                        we  = 1'b1;
                        n_j = jp;
                        if (r_i == i_len - LW'(1)) begin
                            n_last = jp;
                        end
                    end
                    if (r_i == i_len - LW'(1)) begin
                        n_state = TBL_IDLE;
                    end else begin
                        n_i = r_i + LW'(1);
                    end
                end
            end
            default: n_state = TBL_IDLE;
        endcase
    end

    a_prefix_shorter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TBL_BUILD) |-> (r_j < r_i))
        else $error("failure prefix not shorter than scan index");

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (jp <= r_i))
        else $error("failure value exceeds its entry index");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == TBL_IDLE))
        else $error("table rebuild requested while rebuilding");

endmodule

`default_nettype wire

// ----- rtl/core/kmp_engine.sv -----
// Matching engine: walks failure links one per cycle and emits one result per item.
`default_nettype none

module kmp_engine
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LW = $clog2(MAX_PATTERN + 1),
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    localparam int PW = POSITION_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic [LW-1:0]    i_len,
    input  wire logic [PAT_W-1:0] i_pattern,
    input  wire t_in              i_item,
    input  wire logic             i_item_valid,
    output logic                  o_item_pop,
    input  wire t_tbl_status      i_tbl,
    output logic [IW-1:0]         o_rd_addr,
    input  wire logic [LW-1:0]    i_rd_data,
    output t_out                  o_res,
    output logic                  o_res_push,
    input  wire logic             i_res_full,
    output logic                  o_idle
);

    t_eng_state    r_state;
    t_eng_state    n_state;
    logic [7:0]    r_c;
    logic [7:0]    n_c;
    logic [LW-1:0] r_j;
    logic [LW-1:0] n_j;
    logic [PW-1:0] r_cur;
    logic [PW-1:0] n_cur;
    logic [LW-1:0] r_matched;
    logic [LW-1:0] n_matched;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [LW-1:0] j0;
    logic [LW-1:0] jp;
    logic [LW-1:0] nj;
    logic [PW-1:0] start;
    logic          found;
    logic          hit;

    assign hit       = (r_c == pat_byte(i_pattern, 4'(r_j)));
    assign jp        = r_j + LW'(1);
    assign o_rd_addr = IW'(r_j - LW'(1));
    assign o_idle    = (r_state == ENG_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ENG_IDLE;
            r_matched <= '0;
            r_pos     <= '0;
        end else begin
            r_state   <= n_state;
            r_matched <= n_matched;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_j   <= n_j;
        r_cur <= n_cur;
    end

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_j        = r_j;
        n_cur      = r_cur;
        n_matched  = r_matched;
        n_pos      = r_pos;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        found      = 1'b0;
        nj         = '0;
        start      = '0;
        j0         = i_item.restart ? '0 : r_matched;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_item_valid && !i_tbl.busy) begin
                    o_item_pop = 1'b1;
                    n_c        = i_item.text_byte;
                    n_cur      = i_item.restart ? '0 : r_pos;
                    n_j        = (j0 >= i_len) ? '0 : j0;
                    n_state    = ENG_STEP;
                end
            end
            ENG_STEP: begin
                if (i_len != '0 && r_j != '0 && !hit) begin
                    n_j = i_rd_data;
                end else begin
                    if (i_len != '0 && hit) begin
                        if (jp >= i_len) begin
                            // Whole pattern seen: resume from the last failure value.
                            found = 1'b1;
                            nj    = LW'(i_tbl.fail_last);
                            start = r_cur + PW'(1) - PW'(i_len);
                        end else begin
                            nj = jp;
                        end
                    end
                    if (!i_res_full) begin
                        o_res_push        = 1'b1;
                        o_res.match_found = found;
                        o_res.match_start = START_W'(start);
                        n_matched         = nj;
                        n_pos             = (&r_cur) ? r_cur : r_cur + PW'(1);
                        n_state           = ENG_IDLE;
                    end
                end
            end
            default: n_state = ENG_IDLE;
        endcase
        if (i_clear) begin
            n_matched = '0;
        end
    end

    a_pop_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop |-> (r_state == ENG_IDLE && !i_tbl.busy))
        else $error("item taken while engine or table busy");

    a_progress_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ENG_STEP && i_len != '0) |-> (r_j < i_len))
        else $error("match progress reached pattern length");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (!i_res_full && r_state == ENG_STEP))
        else $error("result pushed without space");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == ENG_IDLE && !o_res_push))
        else $error("more than one result for an item");

endmodule

`default_nettype wire
